// File: rtl/unsh_pkg.sv
// Shared types and constants of the 3x3 unsharp mask block.
// Used by unsh_ctrl, unsh_datapath and unsharp_mask_3x3_gray_top.
package unsh_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHARPEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VERT_WEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HORZ_WEIGHT = 3'd5;

  localparam logic [1:0] MODE_ZERO = 2'd0;
  localparam logic [1:0] MODE_MIRROR = 2'd1;
  localparam logic [1:0] MODE_ADJUST = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic [1:0] PROD_KB_LO = 2'd0;
  localparam logic [1:0] PROD_KB_HI = 2'd1;
  localparam logic [1:0] PROD_NUM = 2'd2;
  localparam logic [1:0] PROD_DEN = 2'd3;

  localparam logic [1:0] TAP_LAST = 2'd2;
  localparam logic [3:0] DIV_LAST = 4'd8;

  typedef struct packed {
    logic       accept;
    logic       shift;
    logic       tap_mul;
    logic       tap_acc;
    logic [1:0] tap_row;
    logic [1:0] tap_col;
    logic       prod;
    logic [1:0] prod_idx;
    logic       div;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic emit;
    logic out_busy;
  } status_t;

endpackage

// File: rtl/unsh_ctrl.sv
// Sequencer of the unsharp mask: item intake, window shift, tap loop, products, divide, output load.
// Depends on unsh_pkg; drives the command struct of unsh_datapath.
module unsh_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  unsh_pkg::status_t status_i,
  output unsh_pkg::cmd_t   cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SHIFT = 7'b0000010,
    ST_TAPW  = 7'b0000100,
    ST_TAPA  = 7'b0001000,
    ST_PROD  = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] row_q, row_d, col_q, col_d, pidx_q, pidx_d;
  logic [3:0] didx_q, didx_d;

  always_comb begin
    state_d = state_q;
    row_d = row_q;
    col_d = col_q;
    pidx_d = pidx_q;
    didx_d = didx_q;
    cmd_o = '0;
    cmd_o.tap_row = row_q;
    cmd_o.tap_col = col_q;
    cmd_o.prod_idx = pidx_q;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cmd_o.accept = 1'b1;
          if (!status_i.skip) state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        row_d = '0;
        col_d = '0;
        state_d = status_i.emit ? ST_TAPW : ST_IDLE;
      end
      ST_TAPW: begin
        cmd_o.tap_mul = 1'b1;
        state_d = ST_TAPA;
      end
      ST_TAPA: begin
        cmd_o.tap_acc = 1'b1;
        if (col_q == unsh_pkg::TAP_LAST) begin
          col_d = '0;
          if (row_q == unsh_pkg::TAP_LAST) begin
            pidx_d = '0;
            state_d = ST_PROD;
          end else begin
            row_d = row_q + 2'd1;
            state_d = ST_TAPW;
          end
        end else begin
          col_d = col_q + 2'd1;
          state_d = ST_TAPW;
        end
      end
      ST_PROD: begin
        cmd_o.prod = 1'b1;
        if (pidx_q == unsh_pkg::PROD_DEN) begin
          didx_d = '0;
          state_d = ST_DIV;
        end else begin
          pidx_d = pidx_q + 2'd1;
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        didx_d = didx_q + 4'd1;
        if (didx_q == unsh_pkg::DIV_LAST) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q <= '0;
      col_q <= '0;
      pidx_q <= '0;
      didx_q <= '0;
    end else begin
      state_q <= state_d;
      row_q <= row_d;
      col_q <= col_d;
      pidx_q <= pidx_d;
      didx_q <= didx_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept && !status_i.skip |=> cmd_o.shift)
    else $error("accepted item not followed by window shift");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div && didx_q == unsh_pkg::DIV_LAST |=> state_q == ST_OUT)
    else $error("divide did not end in output state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.tap_mul |=> cmd_o.tap_acc)
    else $error("tap product not accumulated");

endmodule

// File: rtl/unsh_datapath.sv
// Datapath of the unsharp mask: configuration, line store, window, counters,
// tap accumulation, products, restoring divide and output register. Uses unsh_pkg.
module unsh_datapath #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  unsh_pkg::cmd_t                      cmd_i,
  output unsh_pkg::status_t                   status_o,
  input  logic [7:0]                          s_axis_tdata_i,
  input  logic                                s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [7:0]                          m_axis_tdata_o,
  output logic                                m_axis_tlast_o,
  input  logic                                cfg_valid_i,
  input  logic [unsh_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [unsh_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PW = $clog2(MAX_WIDTH + 2);

  logic [1:0] mode_q;
  logic [10:0] cfg_w_q, cfg_h_q;
  logic [15:0] k_q;
  logic [14:0] vsw_q, hsw_q;

  logic [WW-1:0] weff;
  logic [HW-1:0] heff;
  logic [CW-1:0] icol_q, ocol_q, ocol_nxt, addr_q, rd_addr;
  logic [RW-1:0] irow_q, orow_q;
  logic [PW-1:0] pend_q;
  logic ocol_wrap, icol_wrap, frame_end;
  logic op_q;
  logic [7:0] pix_q;
  logic [15:0] mem [MAX_WIDTH];
  logic [15:0] rd_q;
  logic [7:0] win_q [9];

  logic rv0, rv2, cv0, cv2, row_ok, col_ok, use_tap, mode_mirror;
  logic [1:0] sr, sc;
  logic [3:0] widx;
  logic [16:0] vwt, hwt;
  logic [32:0] kw_q, seff;
  logic [7:0] tpix_q;
  logic use_q;
  logic [39:0] accb_q;
  logic [32:0] accs_q;
  logic [40:0] pa_q;
  logic [31:0] pb_q;
  logic [55:0] numb_q, numa;
  logic pos_q;
  logic [56:0] dsh_q, rem_q;
  logic [8:0] q_q;
  logic m_valid_q, m_last_q;
  logic [7:0] m_data_q;

  always_comb begin
    if (cfg_w_q < 11'd3) weff = WW'(3);
    else if (32'(cfg_w_q) > 32'(MAX_WIDTH)) weff = WW'(MAX_WIDTH);
    else weff = WW'(cfg_w_q);
    if (cfg_h_q < 11'd3) heff = HW'(3);
    else if (32'(cfg_h_q) > 32'(MAX_HEIGHT)) heff = HW'(MAX_HEIGHT);
    else heff = HW'(cfg_h_q);
  end

  assign ocol_wrap = 32'(ocol_q) + 32'd1 >= 32'(weff);
  assign icol_wrap = 32'(icol_q) + 32'd1 >= 32'(weff);
  assign ocol_nxt = ocol_wrap ? '0 : ocol_q + 1'b1;
  assign rd_addr = s_axis_tuser_i ? ocol_nxt : icol_q;
  assign frame_end = ocol_wrap && (32'(orow_q) + 32'd1 >= 32'(heff));

  assign status_o.skip = s_axis_tuser_i && (pend_q == '0);
  assign status_o.emit = op_q || (32'(pend_q) > 32'(weff));
  assign status_o.out_busy = m_valid_q && !m_axis_tready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) rd_q <= mem[rd_addr];
    if (cmd_i.shift && !op_q) mem[addr_q] <= {rd_q[7:0], pix_q};
  end

  assign rv0 = orow_q != '0;
  assign rv2 = 32'(orow_q) + 32'd1 < 32'(heff);
  assign cv0 = ocol_q != '0;
  assign cv2 = !ocol_wrap;
  assign mode_mirror = mode_q == unsh_pkg::MODE_MIRROR;

  always_comb begin
    case (cmd_i.tap_row)
      2'd0: row_ok = rv0;
      2'd2: row_ok = rv2;
      default: row_ok = 1'b1;
    endcase
    case (cmd_i.tap_col)
      2'd0: col_ok = cv0;
      2'd2: col_ok = cv2;
      default: col_ok = 1'b1;
    endcase
    sr = (mode_mirror && !row_ok) ? 2'd2 - cmd_i.tap_row : cmd_i.tap_row;
    sc = (mode_mirror && !col_ok) ? 2'd2 - cmd_i.tap_col : cmd_i.tap_col;
    widx = {1'b0, sr, 1'b0} + {2'b0, sr} + {2'b0, sc};
    use_tap = mode_mirror || (row_ok && col_ok);
    vwt = (cmd_i.tap_row == 2'd1) ? 17'h10000 - {1'b0, vsw_q, 1'b0} : {2'b0, vsw_q};
    hwt = (cmd_i.tap_col == 2'd1) ? 17'h10000 - {1'b0, hsw_q, 1'b0} : {2'b0, hsw_q};
    seff = (mode_q == unsh_pkg::MODE_ZERO || mode_mirror) ? 33'h1_0000_0000 : accs_q;
    numa = {pa_q[39:0], 16'b0};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q <= s_axis_tuser_i;
      pix_q <= s_axis_tdata_i;
      addr_q <= rd_addr;
    end
    if (cmd_i.shift) begin
      accb_q <= '0;
      accs_q <= '0;
    end
    if (cmd_i.tap_mul) begin
      kw_q <= 33'(vwt * hwt);
      tpix_q <= win_q[widx];
      use_q <= use_tap;
    end
    if (cmd_i.tap_acc && use_q) begin
      accb_q <= accb_q + 40'(kw_q * tpix_q);
      accs_q <= accs_q + kw_q;
    end
    if (cmd_i.prod) begin
      case (cmd_i.prod_idx)
        unsh_pkg::PROD_KB_LO: pa_q <= 41'(k_q * accb_q[23:0]);
        unsh_pkg::PROD_KB_HI: pb_q <= k_q * accb_q[39:24];
        unsh_pkg::PROD_NUM: begin
          numb_q <= 56'(pa_q) + {pb_q, 24'b0};
          pa_q <= 41'(win_q[4] * seff);
        end
        default: begin
          pos_q <= numa > numb_q;
          rem_q <= {1'b0, numa - numb_q};
          dsh_q <= {49'(seff * (17'h10000 - {1'b0, k_q})), 8'b0};
          q_q <= '0;
        end
      endcase
    end
    if (cmd_i.div) begin
      if (rem_q >= dsh_q) begin
        rem_q <= rem_q - dsh_q;
        q_q <= {q_q[7:0], 1'b1};
      end else begin
        q_q <= {q_q[7:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
    if (cmd_i.load_out) begin
      m_data_q <= !pos_q ? 8'd0 : (q_q[8] ? 8'hFF : q_q[7:0]);
      m_last_q <= frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= unsh_pkg::MODE_ADJUST;
      cfg_w_q <= 11'd512;
      cfg_h_q <= 11'd512;
      k_q <= 16'd32768;
      vsw_q <= 15'd17961;
      hsw_q <= 15'd17961;
      icol_q <= '0;
      irow_q <= '0;
      ocol_q <= '0;
      orow_q <= '0;
      pend_q <= '0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          unsh_pkg::REG_FILTER_MODE: mode_q <= cfg_data_i[1:0];
          unsh_pkg::REG_IMAGE_WIDTH: cfg_w_q <= cfg_data_i[10:0];
          unsh_pkg::REG_IMAGE_HEIGHT: cfg_h_q <= cfg_data_i[10:0];
          unsh_pkg::REG_SHARPEN: k_q <= cfg_data_i;
          unsh_pkg::REG_VERT_WEIGHT: vsw_q <= cfg_data_i[14:0];
          unsh_pkg::REG_HORZ_WEIGHT: hsw_q <= cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (cmd_i.shift) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r*3] <= win_q[r*3+1];
          win_q[r*3+1] <= win_q[r*3+2];
        end
        win_q[2] <= rd_q[15:8];
        win_q[5] <= rd_q[7:0];
        win_q[8] <= op_q ? 8'd0 : pix_q;
        if (!op_q) begin
          pend_q <= pend_q + 1'b1;
          if (icol_wrap) begin
            icol_q <= '0;
            irow_q <= (32'(irow_q) + 32'd1 >= 32'(heff)) ? '0 : irow_q + 1'b1;
          end else begin
            icol_q <= icol_q + 1'b1;
          end
        end
      end
      if (cmd_i.load_out) begin
        m_valid_q <= 1'b1;
        pend_q <= pend_q - 1'b1;
        ocol_q <= ocol_nxt;
        if (ocol_wrap) orow_q <= (32'(orow_q) + 32'd1 >= 32'(heff)) ? '0 : orow_q + 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o = m_data_q;
  assign m_axis_tlast_o = m_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !(m_valid_q && !m_axis_tready_i))
    else $error("output register overwritten before transfer");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> m_valid_q)
    else $error("loaded result not presented");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept && status_o.skip |=> $stable(pend_q) && $stable(ocol_q))
    else $error("drain with nothing pending changed state");

endmodule

// File: rtl/unsharp_mask_3x3_gray_top.sv
// 3x3 Gaussian unsharp mask on 8-bit gray pixels; one item at a time. An
// accepted pixel that causes no result is accepted and shifted into the window,
// a drain with nothing pending is only accepted, and an item that causes a
// result goes through accept, window shift, 9 taps through one shared
// multiply-accumulate (a multiply and an accumulate step each), 4 product steps,
// a 9-step restoring divide and the output load, plus any wait for the output
// register to drain. Results lag pixels by width+1 items; drain items (tuser
// high) push out the rest. Depends on unsh_pkg, unsh_ctrl, unsh_datapath.
module unsharp_mask_3x3_gray_top #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // pixel_in[7:0]
  input  logic                            s_axis_tuser,  // op
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // pixel_out[7:0]
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [unsh_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [unsh_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  unsh_pkg::cmd_t cmd;
  unsh_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  unsh_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  unsh_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

endmodule

// File: verif/unsh_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the 3x3 unsharp mask block: watches the pixel, result and
// configuration channels, predicts each result and compares it. Needs unsh_pkg.
module unsh_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_valid_i,
  input  logic                            s_ready_i,
  input  logic [7:0]                      s_data_i,
  input  logic                            s_user_i,
  input  logic                            m_valid_i,
  input  logic                            m_ready_i,
  input  logic [7:0]                      m_data_i,
  input  logic                            m_last_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [unsh_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [unsh_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              fail_count_o,
  output int                              results_owed_o
);

  localparam int unsigned LINE_LEN = 1024;

  typedef struct {
    logic [7:0] pix;
    logic       frame_end;
  } sharp_px_t;

  sharp_px_t   owed_q[$];
  logic [1:0]  mode_r;
  logic [10:0] width_r, height_r;
  logic [15:0] amount_r;
  logic [14:0] vside_r, hside_r;
  logic [7:0]  line_mem[0:2*LINE_LEN-1];
  logic [7:0]  win[0:8];
  int unsigned in_col, in_row, out_col, out_row, backlog;

  function automatic int unsigned cols_eff();
    if (width_r < 3) return 3;
    if (width_r > LINE_LEN) return LINE_LEN;
    return width_r;
  endfunction

  function automatic int unsigned rows_eff();
    if (height_r < 3) return 3;
    if (height_r > 1024) return 1024;
    return height_r;
  endfunction

  task automatic shift_window(input int unsigned col, input logic [7:0] bottom,
                              input bit store);
    logic [7:0] top, mid;
    top = line_mem[col];
    mid = line_mem[LINE_LEN + col];
    if (store) begin
      line_mem[col] = mid;
      line_mem[LINE_LEN + col] = bottom;
    end
    for (int r = 0; r < 3; r++) begin
      win[r*3] = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = bottom;
  endtask

  function automatic logic [7:0] sharpen_px(input int unsigned w, input int unsigned h);
    longint unsigned vw[3], hw[3], blur, wsum, kw, num_a, num_b, den, q, k;
    bit rv[3], cv[3];
    int sr, sc;
    vw[0] = vside_r; vw[2] = vside_r; vw[1] = 65536 - 2 * longint'(vside_r);
    hw[0] = hside_r; hw[2] = hside_r; hw[1] = 65536 - 2 * longint'(hside_r);
    rv[0] = out_row > 0; rv[1] = 1; rv[2] = out_row + 1 < h;
    cv[0] = out_col > 0; cv[1] = 1; cv[2] = out_col + 1 < w;
    blur = 0;
    wsum = 0;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        kw = vw[a] * hw[b];
        if (mode_r == unsh_pkg::MODE_MIRROR) begin
          sr = rv[a] ? a : 2 - a;
          sc = cv[b] ? b : 2 - b;
          blur += kw * win[sr*3+sc];
        end else if (rv[a] && cv[b]) begin
          blur += kw * win[a*3+b];
          wsum += kw;
        end
      end
    end
    if (mode_r == unsh_pkg::MODE_ZERO || mode_r == unsh_pkg::MODE_MIRROR)
      wsum = 64'd1 << 32;
    k = amount_r;
    num_a = longint'(win[4]) * wsum * 65536;
    num_b = k * blur;
    if (num_a <= num_b) return 8'd0;
    den = wsum * (65536 - k);
    q = (num_a - num_b) / den;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  task automatic produce_result();
    int unsigned w, h;
    sharp_px_t px;
    w = cols_eff();
    h = rows_eff();
    px.frame_end = (out_col + 1 >= w) && (out_row + 1 >= h);
    px.pix = sharpen_px(w, h);
    owed_q.push_back(px);
    backlog--;
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) out_row = 0;
    end
  endtask

  task automatic take_item(input logic is_drain, input logic [7:0] pix);
    int unsigned w, h, col;
    w = cols_eff();
    h = rows_eff();
    if (is_drain) begin
      if (backlog != 0) begin
        col = out_col + 1;
        if (col >= w) col = 0;
        shift_window(col, 8'd0, 0);
        produce_result();
      end
    end else begin
      shift_window(in_col, pix, 1);
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) in_row = 0;
      end
      backlog++;
      if (backlog > w + 1) produce_result();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_r = unsh_pkg::MODE_ADJUST;
      width_r = 11'd512;
      height_r = 11'd512;
      amount_r = 16'd32768;
      vside_r = 15'd17961;
      hside_r = 15'd17961;
      for (int i = 0; i < 2*LINE_LEN; i++) line_mem[i] = 8'd0;
      for (int i = 0; i < 9; i++) win[i] = 8'd0;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0; backlog = 0;
      owed_q.delete();
      fail_count_o = 0;
      results_owed_o = 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        if (owed_q.size() == 0) begin
          $error("result transfer with nothing expected: pixel_out %0d", m_data_i);
          fail_count_o++;
        end else begin
          sharp_px_t px;
          px = owed_q.pop_front();
          if (m_data_i !== px.pix) begin
            $error("pixel_out expected %0d actual %0d", px.pix, m_data_i);
            fail_count_o++;
          end
          if (m_last_i !== px.frame_end) begin
            $error("frame_end expected %0d actual %0d", px.frame_end, m_last_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          unsh_pkg::REG_FILTER_MODE:  mode_r = cfg_data_i[1:0];
          unsh_pkg::REG_IMAGE_WIDTH:  width_r = cfg_data_i[10:0];
          unsh_pkg::REG_IMAGE_HEIGHT: height_r = cfg_data_i[10:0];
          unsh_pkg::REG_SHARPEN:      amount_r = cfg_data_i;
          unsh_pkg::REG_VERT_WEIGHT:  vside_r = cfg_data_i[14:0];
          unsh_pkg::REG_HORZ_WEIGHT:  hside_r = cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) take_item(s_user_i, s_data_i);
      results_owed_o = owed_q.size();
    end
  end

endmodule

// File: verif/tb_unsharp_mask_3x3_gray_top.sv
`timescale 1ns / 1ps
// Top of the unsharp mask testbench: drives pixel, drain and register traffic
// into unsharp_mask_3x3_gray_top and gives the verdict. Needs unsh_pkg, unsh_checker.
module tb_unsharp_mask_3x3_gray_top;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;
  localparam int CYCLE_LIMIT = 4000000;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata = 8'd0;
  logic                            s_axis_tuser = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [7:0]                      m_axis_tdata;
  logic                            m_axis_tlast;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [unsh_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [unsh_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  int                              fail_count, results_owed;
  int                              cycle_count = 0;
  int                              items_sent = 0;
  int                              stored_cols = 0;
  bit                              hold_req = 0;
  bit                              eager_rx = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  unsharp_mask_3x3_gray_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  unsh_checker sharpen_scoreboard (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready),
    .s_data_i(s_axis_tdata), .s_user_i(s_axis_tuser),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_data_i(m_axis_tdata), .m_last_i(m_axis_tlast),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_i(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .fail_count_o(fail_count), .results_owed_o(results_owed)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int idle_span();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Result side: random back-pressure, or always ready in eager mode, and a long
  // hold-off on request once the sender is offering items.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req && s_axis_tvalid) begin
        m_axis_tready = 1'b0;
        repeat (400) @(negedge clk_i);
        hold_req = 0;
      end else if (eager_rx) begin
        m_axis_tready = 1'b1;
      end else begin
        m_axis_tready = (idle_span() == 0);
      end
    end
  end

  task automatic send_item(input logic op, input logic [7:0] pix);
    int gap;
    gap = eager_rx ? 0 : idle_span();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tdata = pix;
    while (!s_axis_tready) @(negedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic write_reg(input logic [unsh_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val[unsh_pkg::CFG_DATA_W-1:0];
    while (!cfg_ready_o) @(negedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (results_owed != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_pixel(input int style);
    if (style == 1) return ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
    if ($urandom_range(3) == 0) return ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
    return $urandom_range(255);
  endfunction

  // One frame: registers, an idle drain, the pixels (with early drains, if early
  // is set, once the line stores hold this width), then drains to flush the rest.
  task automatic run_frame(input int mode, input int w_reg, input int h_reg,
                           input int amount, input int vside, input int hside,
                           input int style, input bit early);
    int w, h;
    settle();
    write_reg(unsh_pkg::REG_FILTER_MODE, mode);
    write_reg(unsh_pkg::REG_IMAGE_WIDTH, w_reg);
    write_reg(unsh_pkg::REG_IMAGE_HEIGHT, h_reg);
    write_reg(unsh_pkg::REG_SHARPEN, amount);
    write_reg(unsh_pkg::REG_VERT_WEIGHT, vside);
    write_reg(unsh_pkg::REG_HORZ_WEIGHT, hside);
    w = (w_reg < 3) ? 3 : (w_reg > 1024) ? 1024 : w_reg;
    h = (h_reg < 3) ? 3 : (h_reg > 1024) ? 1024 : h_reg;
    send_item(OP_DRAIN, $urandom_range(255));
    for (int i = 0; i < w * h; i++) begin
      if (early && stored_cols >= w && $urandom_range(24) == 0)
        send_item(OP_DRAIN, $urandom_range(255));
      send_item(OP_PIXEL, rand_pixel(style));
    end
    for (int i = 0; i <= w + 1; i++) send_item(OP_DRAIN, $urandom_range(255));
    if (w > stored_cols) stored_cols = w;
  endtask

  initial begin
    int rw, rh, amt;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    run_frame(unsh_pkg::MODE_ZERO, 3, 3, 64880, 21845, 21845, 1, 0);
    run_frame(unsh_pkg::MODE_MIRROR, 2, 0, 0, 0, 0, 1, 0);
    run_frame(unsh_pkg::MODE_SPARE, 3, 3, 64880, 0, 21845, 0, 1);

    while (items_sent < 1000) begin
      rw = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(10, 3);
      rh = $urandom_range(6, 3);
      case ($urandom_range(3))
        0: amt = 0;
        1: amt = 64880;
        default: amt = $urandom_range(64880);
      endcase
      eager_rx = ($urandom_range(5) == 0);
      if ($urandom_range(7) == 0) hold_req = 1;
      run_frame($urandom_range(3), rw, rh, amt, $urandom_range(21845),
                $urandom_range(21845), ($urandom_range(4) == 0), 1);
    end
    eager_rx = 0;
    hold_req = 1;
    run_frame(unsh_pkg::MODE_MIRROR, 120, 3, $urandom_range(64880),
              $urandom_range(21845), $urandom_range(21845), 0, 1);
    run_frame(unsh_pkg::MODE_ZERO, 3, 40, $urandom_range(64880), 21845, 0, 0, 1);

    settle();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: unsharp_mask_3x3_gray_top.f
rtl/unsh_pkg.sv
rtl/unsh_ctrl.sv
rtl/unsh_datapath.sv
rtl/unsharp_mask_3x3_gray_top.sv
verif/unsh_checker.sv
verif/tb_unsharp_mask_3x3_gray_top.sv
